// ===== sv/mavg_pkg.sv =====
// Shared constants, types and state encodings for the skip-missing moving average.
package mavg_pkg;

    localparam int DEF_MAX_WINDOW  = 256;
    localparam int DEF_SAMPLE_BITS = 16;

    localparam int WINDOW_REG_BITS = 9;
    localparam logic [WINDOW_REG_BITS-1:0] WINDOW_RESET = 9'd8;

    localparam int ADDR_BITS = 3;
    localparam int DATA_BITS = 32;

    // register index taken from paddr[2]
    localparam logic REG_WINDOW = 1'b0;

    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic ready;
        logic empty;
    } t_flags;

    typedef enum logic {
        FS_IDLE,
        FS_UPDATE
    } t_front_state;

    typedef enum logic [1:0] {
        BS_IDLE,
        BS_DIV,
        BS_DONE
    } t_back_state;

endpackage

// ===== sv/mavg_ram.sv =====
// Generic simple dual-port RAM with registered read data.
module mavg_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sv/mavg_front.sv =====
// Front end: takes requests, keeps the sample ring, running sum and present count.
module mavg_front #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 16,
    localparam int CNT_W = $clog2(MAX_WINDOW + 1),
    localparam int PTR_W = $clog2(MAX_WINDOW),
    localparam int SUM_W = SAMPLE_BITS + CNT_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_clear,
    input  logic [CNT_W-1:0]              i_win,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    input  logic                          i_missing,
    input  logic                          i_q_space,
    output logic                          o_push,
    output logic signed [SUM_W-1:0]       o_sum,
    output logic [CNT_W-1:0]              o_cnt,
    output mavg_pkg::t_flags              o_flags
);
    import mavg_pkg::*;

    t_front_state r_state, n_state;
    logic [PTR_W-1:0] r_pos;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic signed [SUM_W-1:0] r_sum, n_sum;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic r_missing;

    logic accept;
    logic push;
    logic [PTR_W-1:0] pos_eff;
    logic [CNT_W-1:0] pos_inc;
    logic [PTR_W-1:0] n_pos;
    logic evict;
    logic [SAMPLE_BITS:0] rd_entry;
    logic old_missing;
    logic signed [SUM_W-1:0] sub_val, add_val;
    logic dec, inc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_state <= FS_IDLE;
            r_pos   <= '0;
            r_fill  <= '0;
            r_sum   <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (push) begin
                r_pos  <= n_pos;
                r_fill <= n_fill;
                r_sum  <= n_sum;
                r_cnt  <= n_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_sample  <= i_sample;
            r_missing <= i_missing;
        end
    end

    always_comb begin
        n_state = r_state;
        accept  = 1'b0;
        push    = 1'b0;
        o_stall = 1'b1;
        case (r_state)
            FS_IDLE: begin
                o_stall = !i_q_space;
                if (i_valid && i_q_space) begin
                    accept  = 1'b1;
                    n_state = FS_UPDATE;
                end
            end
            FS_UPDATE: begin
                push    = 1'b1;
                n_state = FS_IDLE;
            end
            default: n_state = FS_IDLE;
        endcase
    end

    assign pos_eff = (CNT_W'(r_pos) >= i_win) ? '0 : r_pos;
    assign pos_inc = CNT_W'(pos_eff) + CNT_W'(1);
    assign n_pos   = (pos_inc >= i_win) ? '0 : pos_inc[PTR_W-1:0];
    assign evict   = r_fill >= i_win;

    mavg_ram #(
        .WIDTH(SAMPLE_BITS + 1),
        .DEPTH(MAX_WINDOW)
    ) u_ring (
        .i_clk  (i_clk),
        .i_we   (push),
        .i_waddr(pos_eff),
        .i_wdata({r_missing, r_missing ? {SAMPLE_BITS{1'b0}} : r_sample}),
        .i_raddr(pos_eff),
        .o_rdata(rd_entry)
    );

    assign old_missing = rd_entry[SAMPLE_BITS];

    always_comb begin
        dec     = evict && !old_missing;
        inc     = !r_missing;
        sub_val = dec ? SUM_W'(signed'(rd_entry[SAMPLE_BITS-1:0])) : '0;
        add_val = inc ? SUM_W'(r_sample) : '0;
        n_sum   = r_sum - sub_val + add_val;
        n_cnt   = r_cnt - CNT_W'(dec && (r_cnt != '0)) + CNT_W'(inc);
        n_fill  = (r_fill < i_win) ? r_fill + CNT_W'(1) : r_fill;
    end

    assign o_push        = push;
    assign o_sum         = n_sum;
    assign o_cnt         = n_cnt;
    assign o_flags.ready = n_fill >= i_win;
    assign o_flags.empty = n_cnt == '0;

endmodule

// ===== sv/mavg_queue.sv =====
// Short register queue between the front end and the divider.
module mavg_queue #(
    parameter int WIDTH = 36
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_space,
    input  logic             i_pop,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);
    import mavg_pkg::*;

    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0] r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QCNT_W-1:0] r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_space = r_cnt < QCNT_W'(QUEUE_DEPTH);
    assign o_valid = r_cnt != '0;
    assign o_data  = r_mem[r_rd];

endmodule

// ===== sv/mavg_back.sv =====
// Back end: radix-2 serial divider for the mean and the output register.
module mavg_back #(
    parameter int MAX_WINDOW  = 256,
    parameter int SAMPLE_BITS = 16,
    localparam int CNT_W = $clog2(MAX_WINDOW + 1),
    localparam int SUM_W = SAMPLE_BITS + CNT_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_valid,
    output logic                          o_pop,
    input  logic signed [SUM_W-1:0]       i_sum,
    input  logic [CNT_W-1:0]              i_cnt,
    input  mavg_pkg::t_flags              i_flags,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_average,
    output mavg_pkg::t_flags              o_flags
);
    import mavg_pkg::*;

    localparam int STEP_W = $clog2(SAMPLE_BITS);

    t_back_state r_state, n_state;
    logic [STEP_W-1:0] r_step;
    logic [CNT_W-1:0] r_rem, r_div;
    logic [SAMPLE_BITS-1:0] r_quo;
    logic r_neg;
    t_flags r_job_flags;
    logic r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_average;
    t_flags r_out_flags;

    logic out_free;
    logic load_div, load_zero, step, finish;
    logic [SUM_W-1:0] mag;
    logic [CNT_W:0] trial;
    logic q_bit;

    assign out_free = !r_out_valid || !i_stall;
    assign mag      = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : SUM_W'(i_sum);
    assign trial    = {r_rem, r_quo[SAMPLE_BITS-1]} - {1'b0, r_div};
    assign q_bit    = !trial[CNT_W];

    always_comb begin
        n_state   = r_state;
        o_pop     = 1'b0;
        load_div  = 1'b0;
        load_zero = 1'b0;
        step      = 1'b0;
        finish    = 1'b0;
        case (r_state)
            BS_IDLE: begin
                if (i_q_valid) begin
                    if (i_flags.ready && !i_flags.empty) begin
                        o_pop    = 1'b1;
                        load_div = 1'b1;
                        n_state  = BS_DIV;
                    end else if (out_free) begin
                        o_pop     = 1'b1;
                        load_zero = 1'b1;
                    end
                end
            end
            BS_DIV: begin
                step = 1'b1;
                if (r_step == STEP_W'(SAMPLE_BITS - 1)) begin
                    n_state = BS_DONE;
                end
            end
            BS_DONE: begin
                if (out_free) begin
                    finish  = 1'b1;
                    n_state = BS_IDLE;
                end
            end
            default: n_state = BS_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (load_zero || finish) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // top bits of the magnitude start below the divisor, so SAMPLE_BITS steps suffice
    always_ff @(posedge i_clk) begin
        if (load_div) begin
            r_step      <= '0;
            r_rem       <= mag[SUM_W-1:SAMPLE_BITS];
            r_quo       <= mag[SAMPLE_BITS-1:0];
            r_div       <= i_cnt;
            r_neg       <= i_sum[SUM_W-1];
            r_job_flags <= i_flags;
        end else if (step) begin
            r_step <= r_step + STEP_W'(1);
            r_rem  <= q_bit ? trial[CNT_W-1:0] : {r_rem[CNT_W-2:0], r_quo[SAMPLE_BITS-1]};
            r_quo  <= {r_quo[SAMPLE_BITS-2:0], q_bit};
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_zero) begin
            r_average   <= '0;
            r_out_flags <= i_flags;
        end else if (finish) begin
            r_average   <= r_neg ? -signed'(r_quo) : signed'(r_quo);
            r_out_flags <= r_job_flags;
        end
    end

    assign o_valid   = r_out_valid;
    assign o_average = r_average;
    assign o_flags   = r_out_flags;

endmodule

// ===== sv/moving_average_skip_missing.sv =====
// Top level of the skip-missing moving average: config register, front end, queue, divider.
// Usage:
//   Input channel (i_in_valid / o_in_stall) carries one sample and its missing flag per
//   request; a request is taken at an edge with valid high and stall low.
//   Output channel (o_out_valid / i_out_stall) gives one result per request with ready and
//   empty flags: the present-sample mean truncated toward zero, or 0 if not ready or empty.
//   The window length sits at APB address 0; writing it clears the ring, sum and counts.
// Timing:
//   The front end takes a request only when idle with queue space, reads the ring, then
//   updates while stalling input, and hands the sum and count to a 2-entry queue.
//   The divider is radix-2, one quotient bit per cycle: a result that needs the mean is
//   loaded, divided, then held until the output register is free; one that does not is
//   written as zero once the output register is free. The back end divides one request
//   at a time; the queue lets the front end accept further requests meanwhile.
// Reset and stall:
//   Reset sets the window length to 8 and empties ring, queue and output register.
//   While the receiver stalls, the result holds; the queue fills and then o_in_stall rises.
module moving_average_skip_missing #(
    parameter int MAX_WINDOW  = mavg_pkg::DEF_MAX_WINDOW,
    parameter int SAMPLE_BITS = mavg_pkg::DEF_SAMPLE_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample,
    input  logic                               i_sample_missing,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [SAMPLE_BITS-1:0]      o_average,
    output logic                               o_window_ready,
    output logic                               o_window_empty,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [mavg_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [mavg_pkg::DATA_BITS-1:0]     pwdata,
    output logic [mavg_pkg::DATA_BITS-1:0]     prdata,
    output logic                               pready
);
    import mavg_pkg::*;

    localparam int CNT_W = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W = SAMPLE_BITS + CNT_W;
    localparam int QW    = SUM_W + CNT_W + $bits(t_flags);

    logic [WINDOW_REG_BITS-1:0] r_window_length;
    logic cfg_we;
    logic [CNT_W-1:0] win;

    logic q_push, q_space, q_valid, q_pop;
    logic signed [SUM_W-1:0] f_sum;
    logic [CNT_W-1:0] f_cnt;
    t_flags f_flags;
    logic [QW-1:0] q_out;
    t_flags b_flags;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_WINDOW);
    assign prdata = (paddr[2] == REG_WINDOW) ? DATA_BITS'(r_window_length) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WINDOW_RESET;
        end else if (cfg_we) begin
            r_window_length <= pwdata[WINDOW_REG_BITS-1:0];
        end
    end

    // zero means one, anything past the ring depth saturates
    always_comb begin
        if (r_window_length == '0) begin
            win = CNT_W'(1);
        end else if (32'(r_window_length) > 32'(MAX_WINDOW)) begin
            win = CNT_W'(MAX_WINDOW);
        end else begin
            win = CNT_W'(r_window_length);
        end
    end

    mavg_front #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (cfg_we),
        .i_win    (win),
        .i_valid  (i_in_valid),
        .o_stall  (o_in_stall),
        .i_sample (i_sample),
        .i_missing(i_sample_missing),
        .i_q_space(q_space),
        .o_push   (q_push),
        .o_sum    (f_sum),
        .o_cnt    (f_cnt),
        .o_flags  (f_flags)
    );

    mavg_queue #(
        .WIDTH(QW)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (q_push),
        .i_data ({f_sum, f_cnt, f_flags}),
        .o_space(q_space),
        .i_pop  (q_pop),
        .o_valid(q_valid),
        .o_data (q_out)
    );

    mavg_back #(
        .MAX_WINDOW (MAX_WINDOW),
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_q_valid(q_valid),
        .o_pop    (q_pop),
        .i_sum    (signed'(q_out[QW-1 -: SUM_W])),
        .i_cnt    (q_out[CNT_W+$bits(t_flags)-1 -: CNT_W]),
        .i_flags  (t_flags'(q_out[$bits(t_flags)-1:0])),
        .o_valid  (o_out_valid),
        .i_stall  (i_out_stall),
        .o_average(o_average),
        .o_flags  (b_flags)
    );

    assign o_window_ready = b_flags.ready;
    assign o_window_empty = b_flags.empty;

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> q_space)
        else $error("queue written while full");

    a_front_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall && !cfg_we) |=> o_in_stall)
        else $error("front end took a request while updating");

    a_zero_when_no_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_window_empty || !o_window_ready)) |-> (o_average == '0))
        else $error("non-zero average without a mean");

    a_pop_only_when_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("queue read while empty");

endmodule
